>>> hdl/cbhm_pkg.sv
// Package for the crossed bar hit matcher.
// Field widths, action codes, default sizes and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package cbhm_pkg;

  // Field widths
  localparam int ACTION_W = 3;
  localparam int BAR_W    = 5;
  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;     // difference of two coordinates
  localparam int SQ_W     = 2 * COORD_W;     // |diff| <= 65535, so its square fits
  localparam int DIST_W   = SQ_W + 1;        // sum of two squares
  localparam int PIDX_W   = 4;               // partner index field
  localparam int BARW_W   = 7;               // bar index widened for range checks

  // Stream payload widths
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = ACTION_W;
  localparam int M_TDATA_W = 72;
  localparam int M_TUSER_W = 1;

  // Default sizes
  localparam int MAX_HITS_DEF = 16;
  localparam int NUM_BARS_DEF = 32;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_SET_X = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SET_Y = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ADD   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_MATCH = 3'd4;

  // One candidate hit entering the distance unit
  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] hx;
    logic signed [COORD_W-1:0] hy;
  } cand_t;

  // Running best match held by the distance unit
  typedef struct packed {
    logic                      found;
    logic signed [COORD_W-1:0] best_y;
    logic [DIST_W-1:0]         best_dist;
  } best_t;

endpackage

>>> hdl/cbhm_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cbhm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                            clk,
  input  logic                                            wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
  input  logic [WIDTH-1:0]                                wr_data,
  input  logic                                            rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
  output logic [WIDTH-1:0]                                rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, data holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/cbhm_dist.sv
// Shared distance unit: subtract, square, then sum and keep the nearest candidate.
// Depends on cbhm_pkg.
`timescale 1ns / 1ps

module cbhm_dist #(
  parameter int IDX_W = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  cbhm_pkg::cand_t                     cand,
  input  logic [IDX_W-1:0]                    cand_idx,
  input  logic signed [cbhm_pkg::COORD_W-1:0] qx,
  input  logic signed [cbhm_pkg::COORD_W-1:0] qy,
  output logic                                busy,
  output cbhm_pkg::best_t                     best,
  output logic [IDX_W-1:0]                    best_idx
);

  // Stage A: differences
  logic                                 av;
  logic [IDX_W-1:0]                     aidx;
  logic signed [cbhm_pkg::COORD_W-1:0]  ahy;
  logic signed [cbhm_pkg::DIFF_W-1:0]   dx;
  logic signed [cbhm_pkg::DIFF_W-1:0]   dy;

  // Stage B: squares
  logic                                 bv;
  logic [IDX_W-1:0]                     bidx;
  logic signed [cbhm_pkg::COORD_W-1:0]  bhy;
  logic [cbhm_pkg::SQ_W-1:0]            sqx;
  logic [cbhm_pkg::SQ_W-1:0]            sqy;

  logic signed [2*cbhm_pkg::DIFF_W-1:0] prod_x;
  logic signed [2*cbhm_pkg::DIFF_W-1:0] prod_y;
  logic [cbhm_pkg::DIST_W-1:0]          sum;
  logic                                 better;

  assign prod_x = dx * dx;
  assign prod_y = dy * dy;
  assign sum    = {1'b0, sqx} + {1'b0, sqy};
  assign busy   = av | bv;
  assign better = bv && (!best.found || (sum < best.best_dist));

  // Valid bits of the two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
      bv <= 1'b0;
    end else begin
      av <= cand.valid;
      bv <= av;
    end
  end

  // Payload of the two stages
  always_ff @(posedge clk) begin
    aidx <= cand_idx;
    ahy  <= cand.hy;
    dx   <= {cand.hx[cbhm_pkg::COORD_W-1], cand.hx} - {qx[cbhm_pkg::COORD_W-1], qx};
    dy   <= {cand.hy[cbhm_pkg::COORD_W-1], cand.hy} - {qy[cbhm_pkg::COORD_W-1], qy};
    bidx <= aidx;
    bhy  <= ahy;
    sqx  <= prod_x[cbhm_pkg::SQ_W-1:0];
    sqy  <= prod_y[cbhm_pkg::SQ_W-1:0];
  end

  // Best tracker: strict less-than keeps the earliest entry on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      best.found <= 1'b0;
    end else if (start) begin
      best.found <= 1'b0;
    end else if (better) begin
      best.found <= 1'b1;
    end
    if (!start && better) begin
      best.best_y    <= bhy;
      best.best_dist <= sum;
      best_idx       <= bidx;
    end
  end

endmodule

>>> hdl/crossed_bar_hit_matcher_top.sv
// Top level of the crossed bar hit matcher: stream ports, bar tables, hit list,
// scan sequencer and output register. Depends on cbhm_pkg, cbhm_ram, cbhm_dist.
`timescale 1ns / 1ps

// Table writes, list clears and list appends take effect on their transfer. For a
// match, the sequencer reads one stored hit per cycle from the hit list RAM, looks
// up its bar centre in the y table RAM and feeds it to the single distance unit,
// whose pipeline then drains. The input side is held off while a match runs; a
// finished result sits in the output register, and non-match items keep flowing
// while it waits. Hits beyond MAX_HITS are dropped. Reading a bar table entry
// never written gives an unspecified value; an empty list gives matched = 0 with
// zeroed partner index, y and distance fields.
module crossed_bar_hit_matcher_top #(
  parameter int MAX_HITS = cbhm_pkg::MAX_HITS_DEF,
  parameter int NUM_BARS = cbhm_pkg::NUM_BARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cbhm_pkg::S_TDATA_W-1:0]  s_tdata,  // bar[4:0], coord[20:5], zeros[23:21]
  input  logic [cbhm_pkg::S_TUSER_W-1:0]  s_tuser,  // action[2:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cbhm_pkg::M_TDATA_W-1:0]  m_tdata,  // partner_index[3:0], point_x[19:4],
                                                    // point_y[35:20], min_dist_sq[68:36],
                                                    // zeros[71:69]
  output logic [cbhm_pkg::M_TUSER_W-1:0]  m_tuser   // matched[0]
);

  localparam int BA_W  = $clog2(NUM_BARS);
  localparam int HA_W  = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int CNT_W = $clog2(MAX_HITS + 1);
  localparam int HIT_W = cbhm_pkg::BAR_W + cbhm_pkg::COORD_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Input decode
  logic                                 accept;
  logic [cbhm_pkg::ACTION_W-1:0]        in_action;
  logic [cbhm_pkg::BAR_W-1:0]           in_bar;
  logic signed [cbhm_pkg::COORD_W-1:0]  in_coord;
  logic [cbhm_pkg::BARW_W-1:0]          in_bar_w;
  logic                                 in_bar_ok;

  assign in_action = s_tuser;
  assign in_bar    = s_tdata[cbhm_pkg::BAR_W-1:0];
  assign in_coord  = s_tdata[cbhm_pkg::BAR_W +: cbhm_pkg::COORD_W];
  assign in_bar_w  = {2'b00, in_bar};
  assign in_bar_ok = in_bar_w < cbhm_pkg::BARW_W'(NUM_BARS);
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid & s_tready;

  logic act_set_x, act_set_y, act_clear, act_add, act_match;
  assign act_set_x = accept && (in_action == cbhm_pkg::ACT_SET_X);
  assign act_set_y = accept && (in_action == cbhm_pkg::ACT_SET_Y);
  assign act_clear = accept && (in_action == cbhm_pkg::ACT_CLEAR);
  assign act_add   = accept && (in_action == cbhm_pkg::ACT_ADD);
  assign act_match = accept && (in_action == cbhm_pkg::ACT_MATCH);

  // Hit list fill count
  logic [CNT_W-1:0] count;
  logic             list_full;
  assign list_full = (count == CNT_W'(MAX_HITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (act_clear) begin
      count <= '0;
    end else if (act_add && !list_full) begin
      count <= count + CNT_W'(1);
    end
  end

  // Scan counter and pipeline control
  logic [CNT_W-1:0]  scan_j;
  logic              scan_last;
  logic              hv;
  logic [HA_W-1:0]   hidx;
  logic              pv;
  logic [HA_W-1:0]   pidx;
  logic signed [cbhm_pkg::COORD_W-1:0] ppos;
  logic              pbar_ok;
  logic              dist_busy;

  assign scan_last = ((scan_j + CNT_W'(1)) == count);

  // Memories
  logic [cbhm_pkg::COORD_W-1:0] x_rdata;
  logic [cbhm_pkg::COORD_W-1:0] y_rdata;
  logic [HIT_W-1:0]             hit_rdata;
  logic [cbhm_pkg::BAR_W-1:0]   hit_bar;
  logic [cbhm_pkg::BARW_W-1:0]  hit_bar_w;
  logic                         hit_bar_ok;

  assign hit_bar    = hit_rdata[cbhm_pkg::COORD_W +: cbhm_pkg::BAR_W];
  assign hit_bar_w  = {2'b00, hit_bar};
  assign hit_bar_ok = hit_bar_w < cbhm_pkg::BARW_W'(NUM_BARS);

  cbhm_ram #(.WIDTH(cbhm_pkg::COORD_W), .DEPTH(NUM_BARS)) u_x_ram (
    .clk     (clk),
    .wr_en   (act_set_x && in_bar_ok),
    .wr_addr (in_bar_w[BA_W-1:0]),
    .wr_data (in_coord),
    .rd_en   (act_match),
    .rd_addr (in_bar_w[BA_W-1:0]),
    .rd_data (x_rdata)
  );

  cbhm_ram #(.WIDTH(cbhm_pkg::COORD_W), .DEPTH(NUM_BARS)) u_y_ram (
    .clk     (clk),
    .wr_en   (act_set_y && in_bar_ok),
    .wr_addr (in_bar_w[BA_W-1:0]),
    .wr_data (in_coord),
    .rd_en   (hv),
    .rd_addr (hit_bar_w[BA_W-1:0]),
    .rd_data (y_rdata)
  );

  cbhm_ram #(.WIDTH(HIT_W), .DEPTH(MAX_HITS)) u_hit_ram (
    .clk     (clk),
    .wr_en   (act_add && !list_full),
    .wr_addr (count[HA_W-1:0]),
    .wr_data ({in_bar, in_coord}),
    .rd_en   (state == ST_SCAN),
    .rd_addr (scan_j[HA_W-1:0]),
    .rd_data (hit_rdata)
  );

  // Query registers; x comes straight from the table read data, which holds
  logic signed [cbhm_pkg::COORD_W-1:0] qy;
  logic                                qx_ok;
  logic signed [cbhm_pkg::COORD_W-1:0] qx;

  always_ff @(posedge clk) begin
    if (act_match) begin
      qy    <= in_coord;
      qx_ok <= in_bar_ok;
    end
  end

  assign qx = qx_ok ? x_rdata : '0;

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (act_match) begin
          state_next = (count == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(hv || pv || dist_busy)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan index
  always_ff @(posedge clk) begin
    if (act_match) begin
      scan_j <= '0;
    end else if (state == ST_SCAN) begin
      scan_j <= scan_j + CNT_W'(1);
    end
  end

  // Read pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
      pv <= 1'b0;
    end else begin
      hv <= (state == ST_SCAN);
      pv <= hv;
    end
  end

  // Read pipeline payload
  always_ff @(posedge clk) begin
    hidx    <= scan_j[HA_W-1:0];
    pidx    <= hidx;
    ppos    <= hit_rdata[cbhm_pkg::COORD_W-1:0];
    pbar_ok <= hit_bar_ok;
  end

  // Distance unit
  cbhm_pkg::cand_t cand;
  cbhm_pkg::best_t best;
  logic [HA_W-1:0] best_idx;

  always_comb begin
    cand.valid = pv;
    cand.hx    = ppos;
    cand.hy    = pbar_ok ? y_rdata : '0;
  end

  cbhm_dist #(.IDX_W(HA_W)) u_dist (
    .clk      (clk),
    .rst      (rst),
    .start    (act_match),
    .cand     (cand),
    .cand_idx (pidx),
    .qx       (qx),
    .qy       (qy),
    .busy     (dist_busy),
    .best     (best),
    .best_idx (best_idx)
  );

  // Result fields, zeroed when the list was empty
  logic [HA_W+cbhm_pkg::PIDX_W-1:0] idx_ext;
  logic [cbhm_pkg::PIDX_W-1:0]      res_idx;
  logic [cbhm_pkg::COORD_W-1:0]     res_y;
  logic [cbhm_pkg::DIST_W-1:0]      res_dist;

  assign idx_ext  = {{cbhm_pkg::PIDX_W{1'b0}}, best_idx};
  assign res_idx  = best.found ? idx_ext[cbhm_pkg::PIDX_W-1:0] : '0;
  assign res_y    = best.found ? best.best_y : '0;
  assign res_dist = best.found ? best.best_dist : '0;

  // Output register
  logic out_load;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, res_dist, res_y, qx, res_idx};
      m_tuser <= best.found;
    end
  end

endmodule

>>> hdl/cbhm_checker.sv
// Port-level checks for the crossed bar hit matcher, bound to the top level.
// Depends on cbhm_pkg and crossed_bar_hit_matcher_top.
`timescale 1ns / 1ps

module cbhm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [cbhm_pkg::S_TUSER_W-1:0]  s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [cbhm_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic [cbhm_pkg::M_TUSER_W-1:0]  m_tuser
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // No result straight after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // An empty-list result carries zero partner, y and distance
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |->
      (m_tdata[3:0] == 4'd0) && (m_tdata[35:20] == 16'd0) && (m_tdata[68:36] == 33'd0))
    else $error("unmatched result has nonzero fields");

  // The input side only stalls after a match transfer
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(s_tready) |->
      $past(s_tvalid) && ($past(s_tuser) == cbhm_pkg::ACT_MATCH))
    else $error("input stalled without a match");

endmodule

bind crossed_bar_hit_matcher_top cbhm_checker u_cbhm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> tb/testbench.sv
// Testbench for crossed_bar_hit_matcher_top: loads the bar tables, then drives directed
// and random table, list and match transfers and checks every result against a predictor.
// Depends on cbhm_pkg and the matcher RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int LIST_DEPTH  = cbhm_pkg::MAX_HITS_DEF;
  localparam int BAR_COUNT   = cbhm_pkg::NUM_BARS_DEF;
  localparam longint DIST_CUTOFF = 99999;
  localparam int DRAIN_CYCLES = 40;      // longest match (full list) plus margin
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 370;

  typedef logic [cbhm_pkg::ACTION_W-1:0]        action_t;
  typedef logic [cbhm_pkg::BAR_W-1:0]           bar_t;
  typedef logic signed [cbhm_pkg::COORD_W-1:0]  coord_t;

  typedef struct {
    logic                           matched;
    logic [cbhm_pkg::PIDX_W-1:0]    partner_index;
    coord_t                         point_x;
    coord_t                         point_y;
    logic [cbhm_pkg::DIST_W-1:0]    min_dist_sq;
  } match_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [cbhm_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [cbhm_pkg::S_TUSER_W-1:0] s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [cbhm_pkg::M_TDATA_W-1:0] m_tdata;
  logic [cbhm_pkg::M_TUSER_W-1:0] m_tuser;

  // Predictor state
  coord_t front_x_shadow [BAR_COUNT];
  coord_t rear_y_shadow  [BAR_COUNT];
  bar_t   list_bar_shadow [LIST_DEPTH];
  coord_t list_pos_shadow [LIST_DEPTH];
  int     list_count = 0;

  match_result_t pending_matches[$];
  int            error_count = 0;
  int            useful_items = 0;
  int            cycle_count = 0;
  int            src_idle_pct = 24;
  int            sink_idle_pct = 48;

  crossed_bar_hit_matcher_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL crossed_bar_hit_matcher_top");
      $finish;
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Result checker: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    match_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_matches.size() == 0) begin
        $error("unexpected result transfer: tdata=%h tuser=%h", m_tdata, m_tuser);
        error_count++;
      end else begin
        exp_r = pending_matches.pop_front();
        if (m_tuser[0] !== exp_r.matched) begin
          $error("matched: expected %0d actual %0d", exp_r.matched, m_tuser[0]);
          error_count++;
        end
        if (m_tdata[3:0] !== exp_r.partner_index) begin
          $error("partner_index: expected %0d actual %0d", exp_r.partner_index, m_tdata[3:0]);
          error_count++;
        end
        if (m_tdata[19:4] !== exp_r.point_x) begin
          $error("point_x: expected %0d actual %0d", exp_r.point_x,
                 $signed(m_tdata[19:4]));
          error_count++;
        end
        if (m_tdata[35:20] !== exp_r.point_y) begin
          $error("point_y: expected %0d actual %0d", exp_r.point_y,
                 $signed(m_tdata[35:20]));
          error_count++;
        end
        if (m_tdata[68:36] !== exp_r.min_dist_sq) begin
          $error("min_dist_sq: expected %0d actual %0d", exp_r.min_dist_sq, m_tdata[68:36]);
          error_count++;
        end
      end
    end
  end

  // Update the predictor with one accepted transfer; a match queues its result
  task automatic predict_transfer(input action_t action,
                                  input bar_t bar,
                                  input coord_t coord);
    longint        best;
    longint        cand_dist;
    longint        dx;
    longint        dy;
    int            best_idx;
    bit            found;
    match_result_t r;
    case (action)
      cbhm_pkg::ACT_SET_X: begin
        front_x_shadow[bar] = coord;
        useful_items++;
      end
      cbhm_pkg::ACT_SET_Y: begin
        rear_y_shadow[bar] = coord;
        useful_items++;
      end
      cbhm_pkg::ACT_CLEAR: begin
        list_count = 0;
        useful_items++;
      end
      cbhm_pkg::ACT_ADD: begin
        // appends past a full list are dropped
        if (list_count < LIST_DEPTH) begin
          list_bar_shadow[list_count] = bar;
          list_pos_shadow[list_count] = coord;
          list_count++;
          useful_items++;
        end
      end
      cbhm_pkg::ACT_MATCH: begin
        best = DIST_CUTOFF * DIST_CUTOFF;
        best_idx = 0;
        found = 1'b0;
        for (int j = 0; j < list_count; j++) begin
          dx = longint'(list_pos_shadow[j]) - longint'(front_x_shadow[bar]);
          dy = longint'(rear_y_shadow[list_bar_shadow[j]]) - longint'(coord);
          cand_dist = dx * dx + dy * dy;
          // strict compare: first entry wins a tie
          if (cand_dist < best) begin
            best = cand_dist;
            best_idx = j;
            found = 1'b1;
          end
        end
        r.matched       = found;
        r.partner_index = found ? best_idx[cbhm_pkg::PIDX_W-1:0] : '0;
        r.point_x       = front_x_shadow[bar];
        r.point_y       = found ? rear_y_shadow[list_bar_shadow[best_idx]] : '0;
        r.min_dist_sq   = found ? best[cbhm_pkg::DIST_W-1:0] : '0;
        pending_matches.push_back(r);
        useful_items++;
      end
      default: ; // unused codes are ignored
    endcase
  endtask

  // Send one item; entered and left at a falling edge
  task automatic send_item(input action_t action,
                           input bar_t bar,
                           input coord_t coord);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {3'b000, coord, bar};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_transfer(action, bar, coord);
    @(negedge clk);
  endtask

  // Hold the input off until every predicted result has been received
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Every bar centre gets written, so no match reads an unwritten entry
  task automatic load_bar_tables();
    for (int b = 0; b < BAR_COUNT; b++) begin
      if (b == 0) send_item(cbhm_pkg::ACT_SET_X, bar_t'(b), 16'sh8000);
      else if (b == BAR_COUNT - 1) send_item(cbhm_pkg::ACT_SET_X, bar_t'(b), 16'sh7fff);
      else send_item(cbhm_pkg::ACT_SET_X, bar_t'(b), rand_coord());
      if (b == 0) send_item(cbhm_pkg::ACT_SET_Y, bar_t'(b), 16'sh7fff);
      else if (b == BAR_COUNT - 1) send_item(cbhm_pkg::ACT_SET_Y, bar_t'(b), 16'sh8000);
      else send_item(cbhm_pkg::ACT_SET_Y, bar_t'(b), rand_coord());
    end
  endtask

  task automatic test_directed();
    bar_t q_bar;
    bar_t h_bar;
    q_bar = 5'd10;
    h_bar = 5'd12;
    // empty list: no partner, point_x still reported
    send_item(cbhm_pkg::ACT_MATCH, 5'd5, 16'sd100);
    // unused action codes produce nothing
    for (int k = 1; k <= 3; k++) begin
      send_item(action_t'(cbhm_pkg::ACT_MATCH + k), bar_t'($urandom), rand_coord());
    end
    // largest possible distance, corner to corner
    send_item(cbhm_pkg::ACT_ADD, 5'd0, 16'sh8000);
    send_item(cbhm_pkg::ACT_MATCH, bar_t'(BAR_COUNT - 1), 16'sh8000);
    send_item(cbhm_pkg::ACT_CLEAR, 5'd0, 16'sd0);
    // two identical hits: the first must win
    send_item(cbhm_pkg::ACT_ADD, 5'd7, 16'sd100);
    send_item(cbhm_pkg::ACT_ADD, 5'd7, 16'sd100);
    send_item(cbhm_pkg::ACT_MATCH, 5'd3, 16'sd0);
    // fill the list, then an exact-hit append that must be dropped
    for (int k = 0; k < LIST_DEPTH - 2; k++) begin
      send_item(cbhm_pkg::ACT_ADD, bar_t'($urandom), rand_coord());
    end
    send_item(cbhm_pkg::ACT_ADD, h_bar, front_x_shadow[q_bar]);
    send_item(cbhm_pkg::ACT_MATCH, q_bar, rear_y_shadow[h_bar]);
    wait_results_drained();
  endtask

  // Mostly well-formed event sequences (clear, hits, queries) with some noise
  task automatic test_random(input int n_items);
    int start_count;
    int n_hits;
    int n_queries;
    int sel;
    bar_t last_bar;
    coord_t last_pos;
    start_count = useful_items;
    while (useful_items - start_count < n_items) begin
      sel = $urandom_range(99);
      if (sel < 6) begin
        send_item($urandom_range(1) ? cbhm_pkg::ACT_SET_X : cbhm_pkg::ACT_SET_Y,
                  bar_t'($urandom), rand_coord());
      end else if (sel < 12) begin
        case ($urandom_range(3))
          0: send_item(action_t'(cbhm_pkg::ACT_MATCH + $urandom_range(1, 3)),
                       bar_t'($urandom), coord_t'($urandom));
          1: send_item(cbhm_pkg::ACT_MATCH, bar_t'($urandom), rand_coord());
          2: send_item(cbhm_pkg::ACT_ADD, bar_t'($urandom), rand_coord());
          default: send_item(cbhm_pkg::ACT_CLEAR, bar_t'($urandom), coord_t'($urandom));
        endcase
      end else begin
        n_hits = ($urandom_range(9) == 0) ? $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 2)
                                          : $urandom_range(0, 6);
        n_queries = $urandom_range(1, 4);
        send_item(cbhm_pkg::ACT_CLEAR, bar_t'($urandom), coord_t'($urandom));
        last_bar = bar_t'($urandom);
        last_pos = rand_coord();
        for (int k = 0; k < n_hits; k++) begin
          // repeat a hit now and then to provoke ties
          if ($urandom_range(7) != 0) begin
            last_bar = bar_t'($urandom);
            last_pos = rand_coord();
          end
          send_item(cbhm_pkg::ACT_ADD, last_bar, last_pos);
        end
        for (int k = 0; k < n_queries; k++) begin
          send_item(cbhm_pkg::ACT_MATCH, bar_t'($urandom), rand_coord());
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_idle_pct  = 24;
    sink_idle_pct = 48;
    load_bar_tables();
    test_directed();
    test_random(PHASE_ITEMS);
    wait_results_drained();

    src_idle_pct  = 48;
    sink_idle_pct = 24;
    test_random(PHASE_ITEMS);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random(PHASE_ITEMS);

    // end of stimulus: collect the outstanding results, then watch for strays
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS crossed_bar_hit_matcher_top");
    end else begin
      $display("FAIL crossed_bar_hit_matcher_top");
    end
    $finish;
  end

endmodule
